// File: hdl/rart_pkg.sv
// shared constants, types and helpers for the radian angle reduction pipeline
package rart_pkg;

  // field widths
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned PHASE_W = 16;
  localparam int unsigned SHIFT_W = 4;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic [ADDR_W-1:0] REG_SCALE_SHIFT = 3'd0;

  // remainder datapath
  localparam int unsigned ANGLE_PRESHIFT = 17;
  localparam int unsigned REM_W = 35;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned NUM_REM_STAGES = 25;
  localparam int unsigned DVD_W = BITS_PER_STAGE * NUM_REM_STAGES;
  localparam int unsigned DVD_PAD = DVD_W - ANGLE_W - ANGLE_PRESHIFT;
  localparam logic [REM_W-1:0] TWO_PI_Q32 = 35'd26986075409;

  // multiplier datapath
  localparam int unsigned INV_W = 30;
  localparam logic [INV_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam int unsigned REM_SPLIT = 17;
  localparam int unsigned REM_HI_W = REM_W - REM_SPLIT;
  localparam int unsigned PL_W = REM_SPLIT + INV_W;
  localparam int unsigned PH_W = REM_HI_W + INV_W;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned RESULT_SHIFT = 48;

  // payload carried between remainder stages
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DVD_W-1:0] dvd;
  } rem_stage_t;

  // two-pi modulus adapted to the input format
  function automatic logic [REM_W-1:0] modulus_f(input logic [SHIFT_W-1:0] sh);
    modulus_f = TWO_PI_Q32 >> sh;
  endfunction

endpackage

// File: hdl/rart_rem_stage.sv
// one registered radix-4 step of the restoring remainder computation
module rart_rem_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  rart_pkg::rem_stage_t     in_data_i,
  input  logic [rart_pkg::REM_W-1:0] modulus_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output rart_pkg::rem_stage_t     out_data_o
);
  import rart_pkg::*;

  logic             valid_q;
  rem_stage_t       data_q;
  rem_stage_t       data_d;
  logic [REM_W:0]   t1;
  logic [REM_W:0]   t2;
  logic [REM_W-1:0] r1;
  logic [REM_W-1:0] r2;
  logic [REM_W:0]   mod_ext;

  // stage holds only when full and the next stage holds
  assign in_stall_o = valid_q && out_stall_i;

  // two shift, compare and subtract steps
  always_comb begin
    mod_ext = {1'b0, modulus_i};
    t1 = {in_data_i.rem, in_data_i.dvd[DVD_W-1]};
    r1 = (t1 >= mod_ext) ? REM_W'(t1 - mod_ext) : t1[REM_W-1:0];
    t2 = {r1, in_data_i.dvd[DVD_W-2]};
    r2 = (t2 >= mod_ext) ? REM_W'(t2 - mod_ext) : t2[REM_W-1:0];
    data_d.rem = r2;
    data_d.dvd = {in_data_i.dvd[DVD_W-3:0], 2'b00};
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: hdl/rart_mul.sv
// three-stage multiply by the inverse two-pi constant and phase extraction
module rart_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rart_pkg::REM_W-1:0]   rem_i,
  input  logic [rart_pkg::SHIFT_W-1:0] shift_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rart_pkg::PHASE_W-1:0] phase_o
);
  import rart_pkg::*;

  logic [2:0]          valid_q;
  logic [2:0]          rdy;
  logic [PL_W-1:0]     pl_q;
  logic [PH_W-1:0]     ph_q;
  logic [PROD_W-1:0]   sum_q;
  logic [PROD_W-1:0]   shifted;
  logic [PHASE_W-1:0]  phase_q;

  // per-stage ready, bubbles collapse
  assign rdy[2]     = !valid_q[2] || !out_stall_i;
  assign rdy[1]     = !valid_q[1] || rdy[2];
  assign rdy[0]     = !valid_q[0] || rdy[1];
  assign in_stall_o = !rdy[0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 3'b000;
    end else begin
      if (rdy[0]) valid_q[0] <= in_valid_i;
      if (rdy[1]) valid_q[1] <= valid_q[0];
      if (rdy[2]) valid_q[2] <= valid_q[1];
    end
  end

  // partial products of the remainder halves
  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      pl_q <= PL_W'(rem_i[REM_SPLIT-1:0]) * PL_W'(INV_TWO_PI_Q32);
      ph_q <= PH_W'(rem_i[REM_W-1:REM_SPLIT]) * PH_W'(INV_TWO_PI_Q32);
    end
  end

  // recombine, wrapping at the product width
  always_ff @(posedge clk_i) begin
    if (rdy[1] && valid_q[0]) begin
      sum_q <= PROD_W'({ph_q, {REM_SPLIT{1'b0}}}) + PROD_W'(pl_q);
    end
  end

  // apply format shift and take the top bits
  assign shifted = sum_q << shift_i;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && valid_q[1]) begin
      phase_q <= shifted[RESULT_SHIFT +: PHASE_W];
    end
  end

  assign out_valid_o = valid_q[2];
  assign phase_o     = phase_q;

endmodule

// File: hdl/radian_angle_reduce_to_turn.sv
// top level: angle reduction modulo two pi to a 16-bit turn fraction
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------
//  in      | sink      | in_valid_i / in_stall_o  | angle_i [31:0]
//  out     | source    | out_valid_o / out_stall_i| phase_o [15:0]
//  config  | sink      | apb psel/penable/pready  | scale_shift [3:0]
//
// one transaction per cycle sustained while out_stall_i is low; 25 remainder
// stages retiring two dividend bits each, then three multiplier stages.
// reset clears all valid bits and sets scale_shift to zero.
// a stall on the output holds the last stage; earlier stages keep filling
// any bubbles before the stall reaches the input.
module radian_angle_reduce_to_turn (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rart_pkg::ANGLE_W-1:0]  angle_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rart_pkg::PHASE_W-1:0]  phase_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rart_pkg::ADDR_W-1:0]   paddr,
  input  logic [rart_pkg::DATA_W-1:0]   pwdata,
  output logic [rart_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import rart_pkg::*;

  logic [SHIFT_W-1:0] scale_shift_q;
  logic [REM_W-1:0]   modulus;
  logic               stg_valid [NUM_REM_STAGES+1];
  logic               stg_stall [NUM_REM_STAGES+1];
  rem_stage_t         stg_data  [NUM_REM_STAGES+1];

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_shift_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr == REG_SCALE_SHIFT) begin
      scale_shift_q <= pwdata[SHIFT_W-1:0];
    end
  end

  assign prdata = (paddr == REG_SCALE_SHIFT) ? DATA_W'(scale_shift_q) : '0;

  // shifted modulus; user keeps it stable while items are in flight, block does not enforce it
  assign modulus = modulus_f(scale_shift_q);

  // remainder pipeline input
  assign stg_valid[0]    = in_valid_i;
  assign in_stall_o      = stg_stall[0];
  assign stg_data[0].rem = '0;
  assign stg_data[0].dvd = {{DVD_PAD{1'b0}}, angle_i, {ANGLE_PRESHIFT{1'b0}}};

  // remainder stages
  for (genvar k = 0; k < NUM_REM_STAGES; k++) begin : g_rem
    rart_rem_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[k]),
      .in_stall_o  (stg_stall[k]),
      .in_data_i   (stg_data[k]),
      .modulus_i   (modulus),
      .out_valid_o (stg_valid[k+1]),
      .out_stall_i (stg_stall[k+1]),
      .out_data_o  (stg_data[k+1])
    );
  end

  // multiply and phase extraction
  rart_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stg_valid[NUM_REM_STAGES]),
    .in_stall_o  (stg_stall[NUM_REM_STAGES]),
    .rem_i       (stg_data[NUM_REM_STAGES].rem),
    .shift_i     (scale_shift_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .phase_o     (phase_o)
  );

endmodule

// File: hdl/rart_checker.sv
// port-level checker for the angle reduction block, bound to the top level
module rart_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rart_pkg::PHASE_W-1:0]  phase_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [rart_pkg::ADDR_W-1:0]   paddr,
  input logic [rart_pkg::DATA_W-1:0]   pwdata,
  input logic [rart_pkg::DATA_W-1:0]   prdata,
  input logic                          pready
);
  import rart_pkg::*;

  // a stalled result stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  // a stalled result keeps its value
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(phase_o))
    else $error("output phase changed under stall");

  // back pressure only ever comes from a held result
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back pressure");

  // a written shift reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(psel && penable && pwrite && pready && paddr == REG_SCALE_SHIFT)
      && psel && !pwrite && paddr == REG_SCALE_SHIFT
      |-> prdata == DATA_W'($past(pwdata[SHIFT_W-1:0])))
    else $error("scale_shift readback mismatch");

endmodule

bind radian_angle_reduce_to_turn rart_checker u_rart_checker (.*);

// File: test/tb_radian_angle_reduce_to_turn.sv
// testbench for the radian angle reduction pipeline: random and directed angles
module tb_radian_angle_reduce_to_turn;
  import rart_pkg::*;

  // two-pi constants in q32, kept at full 64-bit width for the predictor
  localparam bit [63:0] TWO_PI_TURN     = 64'd26986075409;
  localparam bit [63:0] INV_TWO_PI_TURN = 64'd683565276;
  localparam bit [63:0] WIDE_MAX        = 64'h0001_FFFF_FFFF_FFFF;

  // config space: index 4 has no register behind it
  localparam logic [ADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;

  localparam int unsigned MAX_WAIT        = 17;
  localparam int unsigned RX_HOLD_CYCLES  = 200;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned PIPE_LATENCY    = 28;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned NUM_PHASES      = 8;

  // expected phases in arrival order, plus mismatch bookkeeping
  class turn_scoreboard;
    bit [PHASE_W-1:0] expected_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned angles_in;

    function bit [PHASE_W-1:0] turn_phase(bit [ANGLE_W-1:0] angle,
                                          bit [SHIFT_W-1:0] sh);
      bit [63:0] modulus;
      bit [63:0] mult;
      bit [63:0] wide;
      bit [63:0] rem;
      bit [63:0] prod;
      modulus = TWO_PI_TURN >> sh;
      mult    = INV_TWO_PI_TURN << sh;
      wide    = {32'd0, angle} << ANGLE_PRESHIFT;
      rem     = wide % modulus;
      // product wraps modulo 2^64 by width
      prod    = rem * mult;
      return prod[63:48];
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void note_angle(bit [ANGLE_W-1:0] angle, bit [SHIFT_W-1:0] sh);
      angles_in++;
      expected_q.push_back(turn_phase(angle, sh));
    endfunction

    function void check_phase(bit [PHASE_W-1:0] got);
      bit [PHASE_W-1:0] want;
      if (expected_q.size() == 0) begin
        flag($sformatf("phase %h arrived with no angle outstanding", got));
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (got !== want) flag($sformatf("phase expected %h actual %h", want, got));
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [ANGLE_W-1:0]   angle_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [PHASE_W-1:0]   phase_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  turn_scoreboard sb = new;
  bit [SHIFT_W-1:0] cur_shift;
  bit [15:0]        shifts_seen;
  bit               hold_req;
  int unsigned      tx_calm;
  int unsigned      idle_cycles = 0;

  radian_angle_reduce_to_turn i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .angle_i     (angle_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .phase_o     (phase_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk_i = ~clk_i;

  // wait length per transaction, with occasional stretches of back-to-back traffic
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(16, 64);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // angle whose widened value lands just below (or just above) the k-th multiple of two pi
  function automatic bit [ANGLE_W-1:0] near_turn(bit [SHIFT_W-1:0] sh, bit [63:0] k, bit above);
    bit [63:0] modulus;
    bit [63:0] kmax;
    bit [63:0] target;
    modulus = TWO_PI_TURN >> sh;
    kmax    = WIDE_MAX / modulus;
    if (k > kmax) k = kmax;
    if (k == 0) k = 1;
    target = above ? k * modulus + 64'd131071 : k * modulus - 64'd1;
    return target[48:17];
  endfunction

  function automatic bit [ANGLE_W-1:0] pick_angle(bit [SHIFT_W-1:0] sh);
    bit [63:0] kmax;
    kmax = WIDE_MAX / (TWO_PI_TURN >> sh);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return near_turn(sh, $urandom_range(1, kmax[31:0]), 1'b0);
      6:          return near_turn(sh, $urandom_range(1, kmax[31:0]), 1'b1);
      7:          return $urandom_range(0, 32'h000F_FFFF);
      8:          return ~$urandom_range(0, 32'h0000_FFFF);
      default:    return (32'd1 << $urandom_range(0, 31)) ^ {32{$urandom_range(0, 1) == 1}};
    endcase
  endfunction

  // sampling of both channels and the progress counter
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_angle(angle_i, cur_shift);
      if (out_valid_o && !out_stall_i) sb.check_phase(phase_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    @(posedge clk_i);
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("no transaction for %0d cycles, %0d phases outstanding",
             idle_cycles, sb.expected_q.size());
    $display("Some tests failed");
    $finish;
  end

  // result side: random stall before each transaction, one long hold on request
  initial begin : result_sink
    int unsigned k;
    int unsigned calm;
    bit          hold_done;
    out_stall_i = 1'b0;
    calm = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i = 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
        out_stall_i = 1'b0;
      end else begin
        k = draw_wait(calm);
        if (k > 0) begin
          out_stall_i = 1'b1;
          repeat (k) @(negedge clk_i);
          out_stall_i = 1'b0;
        end
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // offer one angle and wait for its transaction; starts and ends at a falling edge
  task automatic send_angle(input bit [ANGLE_W-1:0] a, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : draw_wait(tx_calm);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    angle_i = a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stop offering and wait until every expected phase has come back
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == REG_SCALE_SHIFT) begin
      cur_shift = data[SHIFT_W-1:0];
      shifts_seen[cur_shift] = 1'b1;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_reg(input logic [ADDR_W-1:0] addr, input bit [SHIFT_W-1:0] want);
    logic [DATA_W-1:0] got;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = addr;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    if (got !== DATA_W'(want)) begin
      sb.flag($sformatf("scale_shift read expected %h actual %h", want, got));
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // main sequence
  initial begin
    bit [ANGLE_W-1:0] edge_angles[$];
    bit [SHIFT_W-1:0] phase_shifts[4];
    bit [SHIFT_W-1:0] sh;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    angle_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 1'b0;
    tx_calm = 0;
    cur_shift = '0;
    shifts_seen = 16'h0001;
    phase_shifts = '{4'd0, 4'd15, 4'd1, 4'd8};
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset value, then field extremes and near-wrap remainders at shift zero
    check_reg(REG_SCALE_SHIFT, 4'd0);
    edge_angles = '{32'h0, 32'h1, 32'h2, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF,
                    32'hFFFF_0000};
    edge_angles.push_back(near_turn(4'd0, 1, 1'b0));
    edge_angles.push_back(near_turn(4'd0, 1, 1'b1));
    edge_angles.push_back(near_turn(4'd0, WIDE_MAX, 1'b0));
    edge_angles.push_back(near_turn(4'd0, 1000, 1'b0));
    foreach (edge_angles[i]) send_angle(edge_angles[i], 1'b0);
    drain();

    // largest shift, written with all upper bits set
    write_reg(REG_SCALE_SHIFT, 32'hFFFF_FFFF);
    check_reg(REG_SCALE_SHIFT, 4'd15);
    edge_angles = '{32'h0, 32'hFFFF_FFFF, 32'h0000_0006};
    edge_angles.push_back(near_turn(4'd15, 1, 1'b0));
    edge_angles.push_back(near_turn(4'd15, WIDE_MAX, 1'b0));
    edge_angles.push_back(near_turn(4'd15, 12345, 1'b1));
    foreach (edge_angles[i]) send_angle(edge_angles[i], 1'b0);
    drain();

    // write beyond the register map must leave scale_shift alone
    write_reg(UNUSED_REG_ADDR, 32'h0000_0005);
    check_reg(REG_SCALE_SHIFT, 4'd15);

    // random phases, each under its own shift
    for (int p = 0; p < NUM_PHASES; p++) begin
      sh = (p < 4) ? phase_shifts[p] : SHIFT_W'($urandom_range(0, 15));
      write_reg(REG_SCALE_SHIFT, ($urandom & ~32'hF) | DATA_W'(sh));
      check_reg(REG_SCALE_SHIFT, sh);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // long output hold while input keeps coming, so backpressure reaches the input
        if (p == 2 && i == 40) hold_req = 1'b1;
        send_angle(pick_angle(sh), p == 2 && i >= 40 && i < 120);
        // input pause until the pipeline is empty
        if (p == 3 && i == 75) drain();
      end
      drain();
    end

    repeat (PIPE_LATENCY + 12) @(posedge clk_i);
    $display("run covered %0d angles and %0d checked phases over %0d of 16 shift settings",
             sb.angles_in, sb.checked, $countones(shifts_seen));
    if (sb.mismatches != 0) $display("%0d mismatches in total", sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
